// File: rtl/core/lfe_pkg.sv
// shared constants, types and helpers for the toroidal life automaton
package lfe_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SIZE_W   = 7;
  localparam int CMD_W    = 2;
  localparam int CNT_W    = 4;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  typedef logic [MAX_COLS-1:0] row_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // clamp a size register into the supported range
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] s;
    if (r < MIN_SIZE) begin
      s = MIN_SIZE;
    end else if (r > lim) begin
      s = lim;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/lfe_ifs.sv
// valid/ready channels for command words and result words
interface lfe_in_if;
  logic                      valid;
  logic                      ready;
  logic [lfe_pkg::CMD_W-1:0] cmd;
  logic [lfe_pkg::COL_W-1:0] col;
  logic [lfe_pkg::ROW_W-1:0] row;
  logic                      alive_in;

  modport source (output valid, cmd, col, row, alive_in, input ready);
  modport sink (input valid, cmd, col, row, alive_in, output ready);
endinterface

interface lfe_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic bad_coordinate;

  modport source (output valid, cell_value, bad_coordinate, input ready);
  modport sink (input valid, cell_value, bad_coordinate, output ready);
endinterface

// File: rtl/core/lfe_row_unit.sv
// next-generation row from the old rows above, at and below, wrapped at width
module lfe_row_unit (
  input  lfe_pkg::row_t                    above,
  input  lfe_pkg::row_t                    center,
  input  lfe_pkg::row_t                    below,
  input  logic [lfe_pkg::SIZE_W-1:0]       width,
  output lfe_pkg::row_t                    next_row
);

  logic [lfe_pkg::COL_W-1:0] last_col;

  assign last_col = lfe_pkg::COL_W'(width - lfe_pkg::SIZE_W'(1));

  for (genvar x = 0; x < lfe_pkg::MAX_COLS; x++) begin : g_cell
    logic [lfe_pkg::COL_W-1:0] lx;
    logic [lfe_pkg::COL_W-1:0] rx;
    logic [lfe_pkg::CNT_W-1:0] cnt;
    logic                      self_alive;
    logic                      born;

    // wrap neighbours at the width in use
    assign lx = (x == 0) ? last_col : lfe_pkg::COL_W'(x - 1);
    assign rx = (lfe_pkg::SIZE_W'(x + 1) == width) ? '0 : lfe_pkg::COL_W'(x + 1);

    assign self_alive = center[x];
    assign cnt = lfe_pkg::CNT_W'(above[lx]) + lfe_pkg::CNT_W'(above[x])
               + lfe_pkg::CNT_W'(above[rx]) + lfe_pkg::CNT_W'(center[lx])
               + lfe_pkg::CNT_W'(center[rx]) + lfe_pkg::CNT_W'(below[lx])
               + lfe_pkg::CNT_W'(below[x]) + lfe_pkg::CNT_W'(below[rx]);
    assign born = (cnt == lfe_pkg::CNT_W'(3))
               || ((cnt == lfe_pkg::CNT_W'(2)) && self_alive);

    // columns beyond the width keep their old value
    assign next_row[x] = (lfe_pkg::SIZE_W'(x) < width) ? born : self_alive;
  end

endmodule

// File: rtl/core/lfe_grid_store.sv
// row memory of the grid, one row write and one registered row read per cycle
module lfe_grid_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lfe_pkg::ROW_W-1:0]  rd_addr,
  output lfe_pkg::row_t              rd_data,
  input  logic                       wr_en,
  input  logic [lfe_pkg::ROW_W-1:0]  wr_addr,
  input  lfe_pkg::row_t              wr_data
);

  lfe_pkg::row_t                     mem [lfe_pkg::MAX_ROWS];
  logic [lfe_pkg::MAX_ROWS-1:0]      row_valid;
  lfe_pkg::row_t                     rd_raw;
  logic                              rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // a row never written since reset reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// File: rtl/core/life_automaton_toroidal_step_top.sv
// top level: command sequencer for the toroidal life automaton
//
// Grid of up to 64 x 64 one-bit cells on a torus, sized by two registers
// written through cfg_we / cfg_index / cfg_data (index 0 width, 1 height;
// values below 3 act as 3, above 64 act as 64). Write only while idle.
// in_ch carries one command word: write a cell, read a cell, or advance the
// whole grid one generation (rule B3/S23). Every word gives exactly one
// result word on out_ch: cell_value for a read, bad_coordinate when a read or
// write has col or row outside the size in use (the access is then dropped).
// A cell read or write goes through S_CELL to S_DONE; a bad coordinate or
// unused command goes straight to S_DONE; an advance passes S_LOAD_PREV,
// S_LOAD_CUR and S_SWEEP to S_DONE. The advance runs one row a cycle through
// the single row unit, bounded by the row memory's one read and one write port.
// in_ch.ready is high only while the sequencer is idle, so one word is in
// flight at a time; the result register lets the next word be taken while
// a result still waits. If out_ch stalls, the sequencer holds its finished
// result and takes no new word until the result register frees up.
// Reset (rst, synchronous) clears the grid to all dead at once and sets
// both sizes to 64; a command may be taken in the cycle after reset.
module life_automaton_toroidal_step_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lfe_pkg::SIZE_W-1:0]   cfg_data,
  lfe_in_if.sink                       in_ch,
  lfe_out_if.source                    out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_LOAD_PREV,
    S_LOAD_CUR,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                       state;
  logic [lfe_pkg::SIZE_W-1:0]   width_reg;
  logic [lfe_pkg::SIZE_W-1:0]   height_reg;
  logic [lfe_pkg::SIZE_W-1:0]   width;
  logic [lfe_pkg::SIZE_W-1:0]   height;
  logic [lfe_pkg::ROW_W-1:0]    last_row;

  lfe_pkg::row_t                prev_row;
  lfe_pkg::row_t                cur_row;
  lfe_pkg::row_t                saved_row;
  lfe_pkg::row_t                below_sel;
  lfe_pkg::row_t                next_row;
  lfe_pkg::row_t                rd_data;
  lfe_pkg::row_t                wr_data;
  lfe_pkg::row_t                cell_row;
  logic [lfe_pkg::ROW_W-1:0]    rd_addr;
  logic [lfe_pkg::ROW_W-1:0]    wr_addr;
  logic                         wr_en;

  logic [lfe_pkg::ROW_W-1:0]    y;
  lfe_pkg::cmd_t                op;
  logic [lfe_pkg::COL_W-1:0]    op_col;
  logic [lfe_pkg::ROW_W-1:0]    op_row;
  logic                         op_alive;
  logic                         res_value;
  logic                         res_bad;
  logic                         out_valid;
  logic                         out_value;
  logic                         out_bad;

  logic                         accept;
  logic                         in_bad;
  logic                         out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= lfe_pkg::SIZE_W'(lfe_pkg::MAX_COLS);
      height_reg <= lfe_pkg::SIZE_W'(lfe_pkg::MAX_ROWS);
    end else if (cfg_we) begin
      unique case (lfe_pkg::cfg_idx_t'(cfg_index))
        lfe_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
        lfe_pkg::CFG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width    = lfe_pkg::eff_size(width_reg, lfe_pkg::SIZE_W'(lfe_pkg::MAX_COLS));
  assign height   = lfe_pkg::eff_size(height_reg, lfe_pkg::SIZE_W'(lfe_pkg::MAX_ROWS));
  assign last_row = lfe_pkg::ROW_W'(height - lfe_pkg::SIZE_W'(1));

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_bad      = (lfe_pkg::SIZE_W'(in_ch.col) >= width)
                    || (lfe_pkg::SIZE_W'(in_ch.row) >= height);
  assign out_free    = !out_valid || out_ch.ready;

  lfe_grid_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // the last row of a sweep wraps to the saved old first row
  assign below_sel = (y == last_row) ? saved_row : rd_data;

  lfe_row_unit u_row (
    .above    (prev_row),
    .center   (cur_row),
    .below    (below_sel),
    .width    (width),
    .next_row (next_row)
  );

  always_comb begin
    cell_row         = rd_data;
    cell_row[op_col] = op_alive;
  end

  always_comb begin
    unique case (state)
      S_IDLE:      rd_addr = (lfe_pkg::cmd_t'(in_ch.cmd) == lfe_pkg::CMD_STEP)
                             ? last_row : in_ch.row;
      S_LOAD_PREV: rd_addr = '0;
      S_LOAD_CUR:  rd_addr = lfe_pkg::ROW_W'(1);
      S_SWEEP:     rd_addr = y + lfe_pkg::ROW_W'(2);
      default:     rd_addr = op_row;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = y;
    wr_data = next_row;
    if (state == S_SWEEP) begin
      wr_en = 1'b1;
    end else if ((state == S_CELL) && (op == lfe_pkg::CMD_WRITE)) begin
      wr_en   = 1'b1;
      wr_addr = op_row;
      wr_data = cell_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      y         <= '0;
      op        <= lfe_pkg::CMD_NOP;
      res_value <= 1'b0;
      res_bad   <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= lfe_pkg::cmd_t'(in_ch.cmd);
            op_col    <= in_ch.col;
            op_row    <= in_ch.row;
            op_alive  <= in_ch.alive_in;
            res_value <= 1'b0;
            res_bad   <= 1'b0;
            unique case (lfe_pkg::cmd_t'(in_ch.cmd)) inside
              lfe_pkg::CMD_STEP: state <= S_LOAD_PREV;
              lfe_pkg::CMD_WRITE, lfe_pkg::CMD_READ: begin
                if (in_bad) begin
                  res_bad <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  state <= S_CELL;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CELL: begin
          if (op == lfe_pkg::CMD_READ) begin
            res_value <= rd_data[op_col];
          end
          state <= S_DONE;
        end
        S_LOAD_PREV: begin
          prev_row <= rd_data;
          state    <= S_LOAD_CUR;
        end
        S_LOAD_CUR: begin
          cur_row   <= rd_data;
          saved_row <= rd_data;
          y         <= '0;
          state     <= S_SWEEP;
        end
        S_SWEEP: begin
          prev_row <= cur_row;
          cur_row  <= below_sel;
          y        <= y + lfe_pkg::ROW_W'(1);
          if (y == last_row) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_value <= res_value;
            out_bad   <= res_bad;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.cell_value     = out_value;
  assign out_ch.bad_coordinate = out_bad;

endmodule
